### design/assert_macros.svh
// Assertion macros shared by the design files.
// Every assertion samples on the rising edge of clock and is switched off
// while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/mvm_pkg.sv
`timescale 1ns / 1ps

package mvm_pkg;

   // Number of entries in the vector store.
   localparam int MAX_COLUMNS = 256;
   localparam int ADDR_WIDTH  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   localparam int COLUMN_WIDTH  = 8;
   localparam int VALUE_WIDTH   = 16;
   localparam int PRODUCT_WIDTH = 2 * VALUE_WIDTH;
   localparam int SUM_WIDTH     = 40;
   localparam int ROW_WIDTH     = 16;
   localparam int LENGTH_WIDTH  = 9;

   localparam logic [LENGTH_WIDTH-1:0] ROW_LENGTH_RESET = 9'd256;

   // Command codes of an input transfer.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_MATRIX = 1'b1;

   typedef logic [ADDR_WIDTH-1:0]           addr_type;
   typedef logic [COLUMN_WIDTH-1:0]         column_type;
   typedef logic signed [VALUE_WIDTH-1:0]   value_type;
   typedef logic signed [PRODUCT_WIDTH-1:0] product_type;
   typedef logic signed [SUM_WIDTH-1:0]     sum_type;
   typedef logic [ROW_WIDTH-1:0]            row_type;
   typedef logic [LENGTH_WIDTH-1:0]         length_type;

endpackage

### design/mvm_channels.sv
`timescale 1ns / 1ps

// Input channel: vector loads and matrix elements.
interface mvm_req_if;
   logic                  valid;
   logic                  ready;
   logic                  command;
   mvm_pkg::column_type   column;
   mvm_pkg::value_type    element_value;

   modport source (output valid, output command, output column, output element_value,
                   input ready);
   modport sink   (input valid, input command, input column, input element_value,
                   output ready);
endinterface

// Result channel: one finished dot product per matrix row.
interface mvm_rsp_if;
   logic                  valid;
   logic                  ready;
   mvm_pkg::sum_type      row_sum;
   mvm_pkg::row_type      row_number;

   modport source (output valid, output row_sum, output row_number, input ready);
   modport sink   (input valid, input row_sum, input row_number, output ready);
endinterface

### design/mvm_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module mvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      write_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] write_address,
   input  logic [WIDTH-1:0]                          write_data,
   input  logic                                      read_enable,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] read_address,
   output logic [WIDTH-1:0]                          read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data <= mem_ff[read_address];
      end
   end

endmodule

### design/matrix_vector_multiply.sv
`timescale 1ns / 1ps

// Dense matrix-times-vector engine with signed Q8.8 operands.
// The req channel carries two kinds of transfer. A load (command 0) writes
// element_value into the vector store at the given column. A matrix element
// (command 1) is multiplied by the stored vector element at its column and
// added to a running sum; column 0 starts a new sum. When the column equals
// row_length - 1 the finished Q24.16 sum goes out on the rsp channel with
// its row number, which then advances and wraps after 65535.
// The csr port writes row_length (9 bits); write it only while idle.
// Throughput is one transfer per cycle while no result is stalled. The
// store is read when a matrix element is taken, the 16 x 16 product is
// registered in the next stage, and the sum then lands in the output
// register. Loads produce no result.
// Reset clears the running sum, the row counter and all pipeline valid
// bits and sets row_length to 256. The vector store is not cleared and
// must be loaded before use. When the receiver stalls with a result
// waiting, the whole pipeline and the store read port hold, and req_if
// stays not ready until the result is taken; while the output register
// is free or being drained, a new transfer is taken every cycle.
module matrix_vector_multiply (
   input  logic                      clock,
   input  logic                      reset,
   mvm_req_if.sink                   req_if,
   mvm_rsp_if.source                 rsp_if,
   input  logic                      csr_write_enable,
   input  mvm_pkg::length_type       csr_write_data
);

`include "assert_macros.svh"

   // Pipeline moves whenever the output register is free or being drained.
   logic                  advance;
   logic                  req_accept;
   logic                  in_range;
   logic                  is_last;

   logic                  write_enable;
   mvm_pkg::value_type    ram_read_data;

   mvm_pkg::length_type   row_length_ff, row_length_in;

   // Stage 1: store read in flight.
   logic                  valid1_ff, valid1_in;
   logic                  first1_ff, first1_in;
   logic                  last1_ff, last1_in;
   logic                  range1_ff, range1_in;
   mvm_pkg::value_type    value1_ff, value1_in;

   // Stage 2: product registered.
   logic                  valid2_ff, valid2_in;
   logic                  first2_ff, first2_in;
   logic                  last2_ff, last2_in;
   mvm_pkg::product_type  product_ff, product_in;
   mvm_pkg::value_type    vector_element;

   // Stage 3: accumulator and output register.
   mvm_pkg::sum_type      sum_ff, sum_in;
   mvm_pkg::sum_type      product_wide;
   mvm_pkg::row_type      row_ff, row_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mvm_pkg::sum_type      rsp_sum_ff, rsp_sum_in;
   mvm_pkg::row_type      rsp_row_ff, rsp_row_in;

   assign advance    = !rsp_valid_ff || rsp_if.ready;
   assign req_accept = req_if.valid && advance;
   assign req_if.ready = advance;

   assign in_range = (32'(req_if.column) < 32'(mvm_pkg::MAX_COLUMNS));
   assign is_last  = ({1'b0, req_if.column} == (row_length_ff - 9'd1));

   assign write_enable = req_accept && (req_if.command == mvm_pkg::CMD_LOAD) && in_range;

   mvm_ram #(
      .WIDTH (mvm_pkg::VALUE_WIDTH),
      .DEPTH (mvm_pkg::MAX_COLUMNS)
   ) u_vector_store (
      .clock         (clock),
      .write_enable  (write_enable),
      .write_address (mvm_pkg::addr_type'(req_if.column)),
      .write_data    (req_if.element_value),
      .read_enable   (advance),
      .read_address  (mvm_pkg::addr_type'(req_if.column)),
      .read_data     (ram_read_data)
   );

   always_comb begin
      row_length_in = row_length_ff;
      if (csr_write_enable) begin
         row_length_in = csr_write_data;
      end

      valid1_in = valid1_ff;
      first1_in = first1_ff;
      last1_in  = last1_ff;
      range1_in = range1_ff;
      value1_in = value1_ff;
      valid2_in = valid2_ff;
      first2_in = first2_ff;
      last2_in  = last2_ff;
      product_in = product_ff;
      sum_in    = sum_ff;
      row_in    = row_ff;
      rsp_sum_in = rsp_sum_ff;
      rsp_row_in = rsp_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      // A column outside the store reads as zero.
      vector_element = range1_ff ? ram_read_data : '0;
      product_wide   = {{(mvm_pkg::SUM_WIDTH - mvm_pkg::PRODUCT_WIDTH){product_ff[
                         mvm_pkg::PRODUCT_WIDTH-1]}}, product_ff};

      if (advance) begin
         valid1_in = req_accept && (req_if.command == mvm_pkg::CMD_MATRIX);
         first1_in = (req_if.column == '0);
         last1_in  = is_last;
         range1_in = in_range;
         value1_in = req_if.element_value;

         valid2_in  = valid1_ff;
         first2_in  = first1_ff;
         last2_in   = last1_ff;
         product_in = vector_element * value1_ff;

         rsp_valid_in = 1'b0;
         if (valid2_ff) begin
            sum_in = first2_ff ? product_wide : mvm_pkg::sum_type'(sum_ff + product_wide);
            if (last2_ff) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = sum_in;
               rsp_row_in   = row_ff;
               row_in       = row_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= mvm_pkg::ROW_LENGTH_RESET;
         valid1_ff     <= 1'b0;
         valid2_ff     <= 1'b0;
         sum_ff        <= '0;
         row_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_length_ff <= row_length_in;
         valid1_ff     <= valid1_in;
         valid2_ff     <= valid2_in;
         sum_ff        <= sum_in;
         row_ff        <= row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      first1_ff  <= first1_in;
      last1_ff   <= last1_in;
      range1_ff  <= range1_in;
      value1_ff  <= value1_in;
      first2_ff  <= first2_in;
      last2_ff   <= last2_in;
      product_ff <= product_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_row_ff <= rsp_row_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.row_sum    = rsp_sum_ff;
   assign rsp_if.row_number = rsp_row_ff;

   // A new result only comes from a row end leaving the product stage.
   `ASSERT_SAME_CYCLE(a_result_from_row_end, $rose(rsp_valid_ff),
      $past(valid2_ff && last2_ff), "result appeared without a finished row")

   // Each emitted row advances the row counter by exactly one.
   `ASSERT_NEXT_CYCLE(a_row_counter_step, advance && valid2_ff && last2_ff,
      row_ff == 16'($past(row_ff) + 16'd1), "row counter did not advance")

   // While stalled, the product stage and accumulator hold. The product may
   // carry unknown bits from a load that read an empty entry, so it is
   // compared case-exactly.
   `ASSERT_NEXT_CYCLE(a_stall_holds, !advance,
      (product_ff === $past(product_ff)) && $stable(valid2_ff) && $stable(sum_ff),
      "pipeline moved during a stall")

endmodule
